[sv/touch_hud_overlay_pixel_gen_macros.svh]
// Assertion helpers for the overlay block.
`ifndef TOUCH_HUD_OVERLAY_PIXEL_GEN_MACROS_SVH
`define TOUCH_HUD_OVERLAY_PIXEL_GEN_MACROS_SVH

// same-cycle implication, clocked on clk, quiet in reset
`define THOG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define THOG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/thog_pkg.sv]
`default_nettype none
package thog_pkg;

	localparam logic [9:0]  PANEL_WIDTH   = 10'd720;
	localparam logic [10:0] PANEL_HEIGHT  = 11'd1280;
	localparam logic [10:0] PANEL_LX_MAX  = 11'd1279;

	localparam logic [6:0]  VOL_RESET     = 7'd75;
	localparam logic [6:0]  VOL_MAX       = 7'd100;

	localparam logic [15:0] COL_BG        = 16'h18C3;
	localparam logic [15:0] COL_BACK      = 16'hFC00;
	localparam logic [15:0] COL_PLAY      = 16'h07E0;
	localparam logic [15:0] COL_PAUSE     = 16'hFFE0;
	localparam logic [15:0] COL_NEXT      = 16'h001F;
	localparam logic [15:0] COL_FILL      = 16'h07E0;
	localparam logic [15:0] COL_WHITE     = 16'hFFFF;

	// floor(d * 100 / 559) == (d * VOL_RECIP) >> 24 for d up to 559
	localparam logic [30:0] VOL_RECIP     = 31'd3001300;

	typedef enum logic [1:0] {
		ACT_QUERY = 2'd0,
		ACT_TOUCH = 2'd1,
		ACT_SET   = 2'd2
	} thog_action_t;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_STOP   = 3'd1,
		EV_PAUSE  = 3'd2,
		EV_NEXT   = 3'd3,
		EV_VOLUME = 3'd4
	} thog_event_t;

endpackage
`default_nettype wire

[sv/thog_ifs.sv]
`default_nettype none
interface thog_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [9:0]  coord_x;
	logic [10:0] coord_y;
	logic        touching;
	logic [6:0]  set_volume;
	logic        set_paused;

	modport source (
		output valid, action, coord_x, coord_y, touching, set_volume, set_paused,
		input  ready
	);
	modport sink (
		input  valid, action, coord_x, coord_y, touching, set_volume, set_paused,
		output ready
	);
endinterface

interface thog_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_color;
	logic        pixel_covered;
	logic [2:0]  event_code;
	logic [6:0]  volume_now;
	logic        paused_now;

	modport source (
		output valid, pixel_color, pixel_covered, event_code, volume_now, paused_now,
		input  ready
	);
	modport sink (
		input  valid, pixel_color, pixel_covered, event_code, volume_now, paused_now,
		output ready
	);
endinterface
`default_nettype wire

[sv/touch_hud_overlay_pixel_gen.sv]
// Channel  Dir  Beat
// -------  ---  ---------------------------------------------------------
// req      in   action, coord_x, coord_y, touching, set_volume, set_paused
// rsp      out  pixel_color, pixel_covered, event_code, volume_now, paused_now
//
// One beat per clock sustained while rsp is ready.
// Input register, then overlay/touch logic, then result register.
// Volume, paused and last-touch state update as a beat moves into rsp.
// rsp stall holds the result and the input register; req keeps taking a
// beat while the input register can drain. Reset: volume 75, playing.
`default_nettype none
`include "touch_hud_overlay_pixel_gen_macros.svh"

module touch_hud_overlay_pixel_gen
	import thog_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	thog_req_if.sink   req,
	thog_rsp_if.source rsp
);

	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [9:0]  coord_x_s1;
	logic [10:0] coord_y_s1;
	logic        touching_s1;
	logic [6:0]  set_volume_s1;
	logic        set_paused_s1;

	logic        valid_s2;
	logic [15:0] color_s2;
	logic        covered_s2;
	logic [2:0]  event_s2;
	logic [6:0]  volume_s2;
	logic        paused_s2;

	logic [6:0]  volume_q;
	logic        paused_q;
	logic        was_touching_q;

	logic        advance;
	logic        move;

	assign advance   = !valid_s2 || rsp.ready;
	assign move      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	function automatic logic in_box(input logic [10:0] lx, input logic [9:0] ly,
			input logic [10:0] x1, input logic [9:0] y1,
			input logic [10:0] x2, input logic [9:0] y2);
		return (lx >= x1) && (lx <= x2) && (ly >= y1) && (ly <= y2);
	endfunction

	function automatic logic [9:0] abs_diff(input logic [9:0] a, input logic [9:0] b);
		return (a > b) ? 10'(a - b) : 10'(b - a);
	endfunction

	function automatic logic tri_right(input logic [10:0] lx, input logic [9:0] ly,
			input logic [10:0] cx, input logic [9:0] cy, input logic [11:0] half);
		logic [11:0] span;
		span = 12'(lx - cx) + 12'(abs_diff(ly, cy));
		return (lx >= cx) && (span < half);
	endfunction

	function automatic logic tri_left(input logic [10:0] lx, input logic [9:0] ly,
			input logic [10:0] cx, input logic [9:0] cy, input logic [11:0] half);
		logic [11:0] span;
		span = 12'(cx - lx) + 12'(abs_diff(ly, cy));
		return (cx >= lx) && (span < half);
	endfunction

	logic [10:0] lx;
	logic [9:0]  ly;
	logic        in_panel;
	logic [9:0]  fill_depth;
	logic [15:0] fill_lhs;
	logic [15:0] fill_rhs;
	logic        fill_hit;
	logic [30:0] vol_prod;
	logic [6:0]  touch_vol;
	logic [15:0] paint_color;
	logic        paint_hit;

	assign lx       = 11'(PANEL_LX_MAX - coord_y_s1);
	assign ly       = coord_x_s1;
	assign in_panel = (coord_x_s1 < PANEL_WIDTH) && (coord_y_s1 < PANEL_HEIGHT);

	// fill reaches row 639 - floor(vol*559/100); compared without the division
	assign fill_depth = 10'(10'd639 - ly);
	assign fill_lhs   = 16'(16'(fill_depth) * 16'd100);
	assign fill_rhs   = 16'(16'(volume_q) * 16'd559);
	assign fill_hit   = (volume_q != 7'd0) && in_box(lx, ly, 11'd1142, 10'd0, 11'd1273, 10'd639)
		&& (fill_lhs <= fill_rhs);

	assign vol_prod  = 31'(fill_depth) * VOL_RECIP;
	assign touch_vol = vol_prod[30:24];

	// topmost layer first
	always_comb begin
		paint_hit   = 1'b1;
		paint_color = 16'd0;
		priority if (in_box(lx, ly, 11'd920, 10'd656, 11'd936, 10'd703)) begin
			paint_color = COL_WHITE;
		end else if (tri_right(lx, ly, 11'd880, 10'd679, 12'd20)) begin
			paint_color = COL_WHITE;
		end else if (in_box(lx, ly, 11'd660, 10'd648, 11'd1200, 10'd711)) begin
			paint_color = COL_NEXT;
		end else if (!paused_q && in_box(lx, ly, 11'd292, 10'd656, 11'd316, 10'd703)) begin
			paint_color = COL_BG;
		end else if (!paused_q && in_box(lx, ly, 11'd244, 10'd656, 11'd268, 10'd703)) begin
			paint_color = COL_BG;
		end else if (paused_q && tri_right(lx, ly, 11'd280, 10'd679, 12'd24)) begin
			paint_color = COL_BG;
		end else if (in_box(lx, ly, 11'd20, 10'd648, 11'd560, 10'd711)) begin
			paint_color = paused_q ? COL_PAUSE : COL_PLAY;
		end else if (in_box(lx, ly, 11'd0, 10'd640, 11'd1279, 10'd719)) begin
			paint_color = COL_BG;
		end else if (fill_hit) begin
			paint_color = COL_FILL;
		end else if (in_box(lx, ly, 11'd1136, 10'd80, 11'd1279, 10'd639)) begin
			paint_color = COL_BG;
		end else if (in_box(lx, ly, 11'd0, 10'd80, 11'd143, 10'd639)) begin
			paint_color = COL_BG;
		end else if (tri_left(lx, ly, 11'd110, 10'd40, 12'd20)) begin
			paint_color = COL_WHITE;
		end else if (in_box(lx, ly, 11'd20, 10'd16, 11'd200, 10'd63)) begin
			paint_color = COL_BACK;
		end else if (in_box(lx, ly, 11'd0, 10'd0, 11'd1279, 10'd79)) begin
			paint_color = COL_BG;
		end else begin
			paint_hit = 1'b0;
		end
	end

	logic [15:0]  color_nxt;
	logic         covered_nxt;
	thog_event_t  event_nxt;
	logic [6:0]   volume_nxt;
	logic         paused_nxt;
	logic         was_nxt;
	logic         rising;

	assign rising = touching_s1 && !was_touching_q && in_panel;

	always_comb begin
		color_nxt   = 16'd0;
		covered_nxt = 1'b0;
		event_nxt   = EV_NONE;
		volume_nxt  = volume_q;
		paused_nxt  = paused_q;
		was_nxt     = was_touching_q;
		unique case (thog_action_t'(action_s1))
			ACT_QUERY: begin
				if (in_panel && paint_hit) begin
					color_nxt   = paint_color;
					covered_nxt = 1'b1;
				end
			end
			ACT_TOUCH: begin
				was_nxt = touching_s1;
				if (rising) begin
					priority if (ly < 10'd79) begin
						event_nxt = EV_STOP;
					end else if (ly >= 10'd640) begin
						if (lx < 11'd620) begin
							paused_nxt = !paused_q;
							event_nxt  = EV_PAUSE;
						end else if (lx > 11'd680) begin
							event_nxt = EV_NEXT;
						end
					end else if (lx >= 11'd1136 && ly >= 10'd80) begin
						volume_nxt = touch_vol;
						event_nxt  = EV_VOLUME;
					end else begin
						event_nxt = EV_NONE;
					end
				end
			end
			ACT_SET: begin
				volume_nxt = (set_volume_s1 > VOL_MAX) ? VOL_MAX : set_volume_s1;
				paused_nxt = set_paused_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1     <= req.action;
			coord_x_s1    <= req.coord_x;
			coord_y_s1    <= req.coord_y;
			touching_s1   <= req.touching;
			set_volume_s1 <= req.set_volume;
			set_paused_s1 <= req.set_paused;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2       <= 1'b0;
			volume_q       <= VOL_RESET;
			paused_q       <= 1'b0;
			was_touching_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (move) begin
				volume_q       <= volume_nxt;
				paused_q       <= paused_nxt;
				was_touching_q <= was_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			color_s2   <= color_nxt;
			covered_s2 <= covered_nxt;
			event_s2   <= event_nxt;
			volume_s2  <= volume_nxt;
			paused_s2  <= paused_nxt;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.pixel_color   = color_s2;
	assign rsp.pixel_covered = covered_s2;
	assign rsp.event_code    = event_s2;
	assign rsp.volume_now    = volume_s2;
	assign rsp.paused_now    = paused_s2;

	`THOG_ASSERT_NOW(a_vol_range, 1'b1, volume_q <= VOL_MAX, "volume above 100")
	`THOG_ASSERT_NOW(a_cover_no_event, valid_s2 && covered_s2, event_s2 == EV_NONE,
		"covered pixel beat carries an event")
	`THOG_ASSERT_NOW(a_uncovered_black, valid_s2 && !covered_s2, color_s2 == 16'd0,
		"uncovered beat with non-zero colour")
	`THOG_ASSERT_NEXT(a_move_fills_s2, move, valid_s2, "beat lost between stages")
	`THOG_ASSERT_NEXT(a_state_sync, move, volume_q == volume_s2 && paused_q == paused_s2,
		"result state differs from held state")

endmodule
`default_nettype wire
